### rtl/core/pds_pkg.sv
package pds_pkg;

   // the largest normalized step magnitude sits in [2^(NORM_TOP-1), 2^NORM_TOP)
   localparam int NORM_TOP = 24;
   localparam int SEG_BITS = 16;
   localparam logic [SEG_BITS-1:0] SEG_MAX = '1;
   localparam int THR_BITS = 16;
   localparam logic [THR_BITS-1:0] THR_RESET = 16'd3277;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_IDX_THRESHOLD = 1'b0;

   // points seen since path start
   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_TWO  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       norm_step;
      logic       acc_clear;
      logic       mul;
      logic       mul_src_e;
      logic [1:0] sel;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_store;
      logic       finish;
   } pds_cmd_type;

   typedef struct packed {
      logic first;
      logic second;
      logic zero;
      logic norm_hi;
      logic norm_lo;
      logic out_free;
   } pds_status_type;

endpackage

### rtl/core/pds_if.sv
interface pds_req_if #(parameter int COORD_BITS = 24) ();
   logic                         valid;
   logic                         ready;
   logic                         path_start;
   logic signed [COORD_BITS-1:0] px;
   logic signed [COORD_BITS-1:0] py;
   logic signed [COORD_BITS-1:0] pz;

   modport source(output valid, path_start, px, py, pz, input ready);
   modport sink(input valid, path_start, px, py, pz, output ready);
endinterface

interface pds_rsp_if ();
   logic        valid;
   logic        ready;
   logic        new_segment;
   logic [15:0] segment_index;
   logic        zero_step;

   modport source(output valid, new_segment, segment_index, zero_step, input ready);
   modport sink(input valid, new_segment, segment_index, zero_step, output ready);
endinterface

### rtl/core/pds_ctrl.sv
module pds_ctrl
   import pds_pkg::*;
#(
   parameter int DIR_FRAC_BITS = 15
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  pds_status_type status,
   output pds_cmd_type    cmd
);

   localparam int QW = DIR_FRAC_BITS + 2;
   localparam logic [4:0] SQRT_LAST = 5'd31;
   localparam logic [4:0] DIV_LAST = 5'(QW - 1);

   typedef enum logic [3:0] {
      IDLE, CHECK, NORM, SQ, SQ_WAIT, SQRT_INIT, SQRT,
      DIV_INIT, DIV, DIV_STORE, DIST, DIST_WAIT, FINISH
   } state_type;

   state_type  state_ff;
   logic [4:0] cnt_ff;
   logic [1:0] idx_ff;

   assign req_ready = (state_ff == IDLE);

   // decode commands from the current state
   always_comb begin
      cmd = '0;
      cmd.sel = idx_ff;
      unique case (state_ff)
         IDLE:      cmd.load = req_valid;
         NORM:      cmd.norm_step = status.norm_hi | status.norm_lo;
         SQ: begin
            cmd.mul = 1'b1;
            cmd.sel = cnt_ff[1:0];
         end
         SQRT_INIT: cmd.sqrt_init = 1'b1;
         // clear the sum of squares once the root has taken it
         SQRT: begin
            cmd.sqrt_step = 1'b1;
            cmd.acc_clear = 1'b1;
         end
         DIV_INIT:  cmd.div_init = 1'b1;
         DIV:       cmd.div_step = 1'b1;
         DIV_STORE: cmd.div_store = 1'b1;
         DIST: begin
            cmd.mul = 1'b1;
            cmd.mul_src_e = 1'b1;
            cmd.sel = cnt_ff[1:0];
         end
         FINISH:    cmd.finish = status.out_free;
         default:   cmd.acc_clear = (state_ff == CHECK);
      endcase
   end

   // sequence one request through normalize, sqrt, divide and compare
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         unique case (state_ff)
            IDLE: if (req_valid) state_ff <= CHECK;
            CHECK: begin
               cnt_ff <= '0;
               state_ff <= (status.first || status.zero) ? FINISH : NORM;
            end
            NORM: if (!status.norm_hi && !status.norm_lo) state_ff <= SQ;
            SQ: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd2) state_ff <= SQ_WAIT;
            end
            SQ_WAIT: state_ff <= SQRT_INIT;
            SQRT_INIT: begin
               cnt_ff <= '0;
               state_ff <= SQRT;
            end
            SQRT: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == SQRT_LAST) begin
                  idx_ff <= '0;
                  state_ff <= DIV_INIT;
               end
            end
            DIV_INIT: begin
               cnt_ff <= '0;
               state_ff <= DIV;
            end
            DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == DIV_LAST) state_ff <= DIV_STORE;
            end
            DIV_STORE: begin
               cnt_ff <= '0;
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  state_ff <= status.second ? FINISH : DIST;
               end else begin
                  state_ff <= DIV_INIT;
               end
            end
            DIST: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd2) state_ff <= DIST_WAIT;
            end
            DIST_WAIT: state_ff <= FINISH;
            FINISH: if (status.out_free) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

### rtl/core/pds_datapath.sv
module pds_datapath
   import pds_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int DIR_FRAC_BITS = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pds_cmd_type                  cmd,
   output pds_status_type               status,
   input  logic                         path_start,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic signed [COORD_BITS-1:0] pz,
   input  logic [THR_BITS-1:0]          threshold,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_new_segment,
   output logic [SEG_BITS-1:0]          rsp_segment_index,
   output logic                         rsp_zero_step
);

   localparam int C   = COORD_BITS;
   localparam int F   = DIR_FRAC_BITS;
   localparam int DW  = C + 1;
   localparam int AW  = (C + 1 > NORM_TOP) ? C + 1 : NORM_TOP;
   localparam int UW  = F + 1;
   localparam int EW  = F + 2;
   localparam int MW  = (NORM_TOP > F + 1) ? NORM_TOP : F + 1;
   localparam int SW  = 2 * MW + 2;
   localparam int XW  = 64;
   localparam int LW  = 32;
   localparam int QW  = F + 2;
   localparam int NW  = LW + QW;
   localparam logic [QW-1:0] LIM = QW'((1 << F) - 1);

   logic signed [C-1:0]  prev_ff [3];
   logic signed [UW-1:0] ref_ff [3];
   logic signed [UW-1:0] u_ff [3];
   logic [1:0]           seen_ff;
   logic [SEG_BITS-1:0]  seg_ff;
   logic [AW-1:0]        a_ff [3];
   logic [2:0]           neg_ff;
   logic                 first_ff, second_ff, zero_ff;
   logic [2*MW-1:0]      prod_ff;
   logic                 prod_vld_ff;
   logic [SW-1:0]        acc_ff;
   logic [2*THR_BITS-1:0] thr2_ff;
   logic [XW-1:0]        x_ff, r_ff, bit_ff;
   logic [NW-1:0]        num_ff, dsh_ff;
   logic [QW-1:0]        q_ff;
   logic                 rsp_vld_ff, rsp_ns_ff, rsp_zs_ff;
   logic [SEG_BITS-1:0]  rsp_seg_ff;

   logic signed [C-1:0]  p_in [3];
   logic signed [DW-1:0] d [3];
   logic [AW-1:0]        m;
   logic signed [EW-1:0] e;
   logic [EW-1:0]        e_abs;
   logic [MW-1:0]        mul_op;
   logic [XW-1:0]        trial;
   logic [QW-1:0]        q_clip;
   logic                 brk;

   assign p_in[0] = px;
   assign p_in[1] = py;
   assign p_in[2] = pz;

   // step from the current point back to the previous one
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d[i] = DW'(prev_ff[i]) - DW'(p_in[i]);
      end
   end

   // largest magnitude steers the normalizing shift
   always_comb begin
      m = a_ff[0];
      if (a_ff[1] > m) m = a_ff[1];
      if (a_ff[2] > m) m = a_ff[2];
   end

   assign status.first    = first_ff;
   assign status.second   = second_ff;
   assign status.zero     = zero_ff;
   assign status.norm_hi  = (m >> NORM_TOP) != '0;
   assign status.norm_lo  = (m >> (NORM_TOP - 1)) == '0;
   assign status.out_free = !rsp_vld_ff || rsp_ready;

   // multiplier operand: step magnitude or direction error
   always_comb begin
      e = EW'(ref_ff[cmd.sel]) - EW'(u_ff[cmd.sel]);
      e_abs = e[EW-1] ? EW'(-e) : EW'(e);
      if (cmd.mul_src_e) begin
         mul_op = MW'(e_abs);
      end else begin
         mul_op = MW'(a_ff[cmd.sel][NORM_TOP-1:0]);
      end
   end

   assign trial  = r_ff + bit_ff;
   assign q_clip = (q_ff > LIM) ? LIM : q_ff;
   assign brk    = acc_ff > SW'(thr2_ff);

   // running path state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= '0;
            ref_ff[i] <= '0;
         end
         seen_ff <= SEEN_NONE;
         seg_ff <= '0;
      end else if (cmd.load) begin
         for (int i = 0; i < 3; i++) prev_ff[i] <= p_in[i];
         if (path_start) begin
            for (int i = 0; i < 3; i++) ref_ff[i] <= '0;
            seen_ff <= SEEN_NONE;
            seg_ff <= '0;
         end
      end else if (cmd.finish) begin
         priority if (first_ff) begin
            seen_ff <= SEEN_ONE;
         end else if (zero_ff) begin
            seen_ff <= seen_ff;
         end else if (second_ff) begin
            for (int i = 0; i < 3; i++) ref_ff[i] <= u_ff[i];
            seen_ff <= SEEN_TWO;
         end else if (brk) begin
            for (int i = 0; i < 3; i++) ref_ff[i] <= u_ff[i];
            if (seg_ff != SEG_MAX) seg_ff <= seg_ff + 1'b1;
         end
      end
   end

   // capture the step and normalize its magnitudes
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= d[i][DW-1];
            a_ff[i] <= d[i][DW-1] ? AW'(-d[i]) : AW'(d[i]);
         end
         zero_ff <= (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
         first_ff <= path_start || (seen_ff == SEEN_NONE);
         second_ff <= !path_start && (seen_ff == SEEN_ONE);
      end else if (cmd.norm_step) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= status.norm_hi ? (a_ff[i] >> 1) : (a_ff[i] << 1);
         end
      end
   end

   // shared squarer and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul;
      end
      prod_ff <= mul_op * mul_op;
      thr2_ff <= threshold * threshold;
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + SW'(prod_ff);
      end
   end

   // bit-pair square root, one result bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         x_ff <= XW'(acc_ff) << 12;
         r_ff <= '0;
         bit_ff <= XW'(1) << (XW - 2);
      end else if (cmd.sqrt_step) begin
         if (x_ff >= trial) begin
            x_ff <= x_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // restoring division of each magnitude by the length
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         num_ff <= (NW'(a_ff[cmd.sel][NORM_TOP-1:0]) << (F + 6)) + NW'(r_ff[LW-1:1]);
         dsh_ff <= NW'(r_ff[LW-1:0]) << (QW - 1);
         q_ff <= '0;
      end else if (cmd.div_step) begin
         if (num_ff >= dsh_ff) begin
            num_ff <= num_ff - dsh_ff;
            q_ff <= {q_ff[QW-2:0], 1'b1};
         end else begin
            q_ff <= {q_ff[QW-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.div_store) begin
         u_ff[cmd.sel] <= neg_ff[cmd.sel] ? -UW'(q_clip) : UW'(q_clip);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_ns_ff <= first_ff || (!zero_ff && !second_ff && brk);
         rsp_zs_ff <= !first_ff && zero_ff;
         if (!first_ff && !zero_ff && !second_ff && brk && seg_ff != SEG_MAX) begin
            rsp_seg_ff <= seg_ff + 1'b1;
         end else begin
            rsp_seg_ff <= seg_ff;
         end
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_new_segment   = rsp_ns_ff;
   assign rsp_segment_index = rsp_seg_ff;
   assign rsp_zero_step     = rsp_zs_ff;

endmodule

### rtl/core/polyline_direction_segmenter_core.sv
// channel | dir | handshake      | payload
// req_ch  | in  | valid/ready    | path_start, px, py, pz
// rsp_ch  | out | valid/ready    | new_segment, segment_index, zero_step
// csr_*   | in  | psel/penable   | break_threshold at byte address 0
//
// A point that is the first of a path or repeats the previous one goes from CHECK to FINISH.
// Otherwise it takes at most 23 normalizing shifts, the squares, the square root and
// three serial divides, then the compare; the second point of a path skips the compare.
// The 32-step square root and the three serial divides dominate.
// Synchronous reset clears the path state; break_threshold resets to 3277.
// One request is in flight at a time; a held result stalls only the next finish.
module polyline_direction_segmenter_core
   import pds_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int DIR_FRAC_BITS = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   pds_req_if.sink                  req_ch,
   pds_rsp_if.source                rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   pds_cmd_type    cmd;
   pds_status_type status;
   logic [THR_BITS-1:0] thr_ff;
   logic                csr_hit;

   // threshold register
   assign csr_hit    = csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_THRESHOLD;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? 32'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         thr_ff <= csr_pwdata[THR_BITS-1:0];
      end
   end

   pds_ctrl #(
      .DIR_FRAC_BITS(DIR_FRAC_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   pds_datapath #(
      .COORD_BITS   (COORD_BITS),
      .DIR_FRAC_BITS(DIR_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .path_start       (req_ch.path_start),
      .px               (req_ch.px),
      .py               (req_ch.py),
      .pz               (req_ch.pz),
      .threshold        (thr_ff),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_new_segment  (rsp_ch.new_segment),
      .rsp_segment_index(rsp_ch.segment_index),
      .rsp_zero_step    (rsp_ch.zero_step)
   );

endmodule

### rtl/core/pds_checker.sv
module pds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_new_segment,
   input logic        rsp_zero_step,
   input logic [15:0] rsp_segment_index
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segment_index))
      else $error("result dropped or changed while stalled");

   // block is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a repeated point never opens a segment
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_new_segment && rsp_zero_step))
      else $error("new segment and zero step both set");

   // nothing pending out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind polyline_direction_segmenter_core pds_checker u_pds_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_new_segment  (rsp_ch.new_segment),
   .rsp_zero_step    (rsp_ch.zero_step),
   .rsp_segment_index(rsp_ch.segment_index)
);
